### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated: next-cycle implication");

`endif

### hw/rtl/fmm_pkg.sv
// shared constants and command/status types for filtered_min_max_mean
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps

package fmm_pkg;

  // default widths of a sample and of the sample counter
  localparam int unsigned FMM_VALUE_BITS = 24;
  localparam int unsigned FMM_COUNT_BITS = 16;

  // sensor code that selects two-value averaging
  localparam logic [7:0] PRESSURE_CODE = 8'd80;

  // configuration register file
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned CFG_REG_BITS  = 8;
  localparam logic REG_TARGET_PATIENT = 1'b0;
  localparam logic REG_TARGET_SENSOR  = 1'b1;
  localparam logic [CFG_REG_BITS-1:0] TARGET_PATIENT_RST = 8'd0;
  localparam logic [CFG_REG_BITS-1:0] TARGET_SENSOR_RST  = PRESSURE_CODE;

  // controller to datapath commands
  typedef struct packed {
    logic accumulate;
    logic div_load;
    logic div_step;
    logic load_out;
  } fmm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
  } fmm_status_t;

endpackage

### hw/rtl/fmm_if.sv
// valid/ready stream interfaces for the reading input and the statistics output
// depends on fmm_pkg for default widths
`timescale 1ns / 1ps

interface fmm_in_if
  import fmm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = FMM_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         reading_valid;
  logic [7:0]                   patient_tag;
  logic [7:0]                   sensor_type;
  logic signed [VALUE_BITS-1:0] first_value;
  logic signed [VALUE_BITS-1:0] second_value;
  logic                         last_reading;

  modport source (
    output valid, reading_valid, patient_tag, sensor_type, first_value, second_value,
    output last_reading,
    input  ready
  );
  modport sink (
    input  valid, reading_valid, patient_tag, sensor_type, first_value, second_value,
    input  last_reading,
    output ready
  );
endinterface

interface fmm_out_if
  import fmm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = FMM_VALUE_BITS,
  parameter int unsigned COUNT_BITS = FMM_COUNT_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] min_out;
  logic signed [VALUE_BITS-1:0] max_out;
  logic signed [VALUE_BITS-1:0] mean_out;
  logic [COUNT_BITS-1:0]        match_count;
  logic                         overflow;

  modport source (
    output valid, min_out, max_out, mean_out, match_count, overflow,
    input  ready
  );
  modport sink (
    input  valid, min_out, max_out, mean_out, match_count, overflow,
    output ready
  );
endinterface

### hw/rtl/fmm_cfg.sv
// apb-style register file holding the patient and sensor targets
// depends on fmm_pkg for address/data widths and register codes
`timescale 1ns / 1ps

module fmm_cfg
  import fmm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [CFG_REG_BITS-1:0]  target_patient,
  output logic [CFG_REG_BITS-1:0]  target_sensor
);

  logic [CFG_REG_BITS-1:0] patient_r, patient_nxt;
  logic [CFG_REG_BITS-1:0] sensor_r, sensor_nxt;
  logic                    wr_en;
  logic                    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // register write decode
  always_comb begin
    patient_nxt = patient_r;
    sensor_nxt  = sensor_r;
    if (wr_en) begin
      case (reg_sel)
        REG_TARGET_PATIENT: patient_nxt = pwdata[CFG_REG_BITS-1:0];
        REG_TARGET_SENSOR:  sensor_nxt  = pwdata[CFG_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patient_r <= TARGET_PATIENT_RST;
      sensor_r  <= TARGET_SENSOR_RST;
    end else begin
      patient_r <= patient_nxt;
      sensor_r  <= sensor_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_TARGET_PATIENT: prdata = {{(APB_DATA_BITS-CFG_REG_BITS){1'b0}}, patient_r};
      REG_TARGET_SENSOR:  prdata = {{(APB_DATA_BITS-CFG_REG_BITS){1'b0}}, sensor_r};
      default:            prdata = '0;
    endcase
  end

  assign target_patient = patient_r;
  assign target_sensor  = sensor_r;

endmodule

### hw/rtl/fmm_ctrl.sv
// controller: sequences accumulation, the mean division and the result transfer
// depends on fmm_pkg for command and status types
`timescale 1ns / 1ps

module fmm_ctrl
  import fmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output fmm_cmd_t    cmd,
  input  fmm_status_t status
);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_ready = (state_r == ST_ACC);
  assign in_fire  = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_ACC: begin
        cmd.accumulate = in_fire;
        if (in_fire && in_last) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/fmm_dp.sv
// datapath: reading filter, running statistics, serial divider, result register
// depends on fmm_pkg for command and status types
`timescale 1ns / 1ps

module fmm_dp
  import fmm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = FMM_VALUE_BITS,
  parameter int unsigned COUNT_BITS = FMM_COUNT_BITS
)(
  input  logic                         clk,
  input  logic                         rst_n,
  input  fmm_cmd_t                     cmd,
  output fmm_status_t                  status,
  input  logic [CFG_REG_BITS-1:0]      target_patient,
  input  logic [CFG_REG_BITS-1:0]      target_sensor,
  input  logic                         reading_valid,
  input  logic [7:0]                   patient_tag,
  input  logic [7:0]                   sensor_type,
  input  logic signed [VALUE_BITS-1:0] first_value,
  input  logic signed [VALUE_BITS-1:0] second_value,
  output logic signed [VALUE_BITS-1:0] min_out,
  output logic signed [VALUE_BITS-1:0] max_out,
  output logic signed [VALUE_BITS-1:0] mean_out,
  output logic [COUNT_BITS-1:0]        match_count,
  output logic                         overflow
);

  localparam int unsigned SUM_BITS  = VALUE_BITS + COUNT_BITS;
  localparam int unsigned STEP_BITS = $clog2(SUM_BITS);

  // running statistics
  logic                         seen_r, seen_nxt;
  logic signed [VALUE_BITS-1:0] min_r, min_nxt;
  logic signed [VALUE_BITS-1:0] max_r, max_nxt;
  logic signed [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]        count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;

  // divider state
  logic [COUNT_BITS:0]          rem_r, rem_nxt;
  logic [SUM_BITS-1:0]          quo_r, quo_nxt;
  logic [COUNT_BITS-1:0]        div_r, div_nxt;
  logic                         neg_r, neg_nxt;
  logic [STEP_BITS-1:0]         step_r, step_nxt;

  // result register
  logic signed [VALUE_BITS-1:0] min_out_r, max_out_r, mean_out_r;
  logic [COUNT_BITS-1:0]        count_out_r;
  logic                         ovf_out_r;

  logic                         match;
  logic signed [VALUE_BITS:0]   pair_sum;
  logic signed [VALUE_BITS-1:0] sample;
  logic                         at_cap;
  logic [COUNT_BITS:0]          rem_shift;
  logic                         rem_ge;
  logic [SUM_BITS-1:0]          quo_signed;
  logic                         have_stats;

  // filter and sample selection; pressure averages with a floor shift
  assign match    = reading_valid && (patient_tag == target_patient)
                    && (sensor_type == target_sensor);
  assign pair_sum = {first_value[VALUE_BITS-1], first_value}
                    + {second_value[VALUE_BITS-1], second_value};
  assign sample   = (target_sensor == PRESSURE_CODE) ? pair_sum[VALUE_BITS:1] : first_value;
  assign at_cap   = (count_r == {COUNT_BITS{1'b1}});

  // statistics update, cleared once the result is captured
  always_comb begin
    seen_nxt  = seen_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.load_out) begin
      seen_nxt  = 1'b0;
      min_nxt   = '0;
      max_nxt   = '0;
      sum_nxt   = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.accumulate && match) begin
      if (at_cap) begin
        ovf_nxt = 1'b1;
      end else begin
        seen_nxt  = 1'b1;
        if (!seen_r || (sample < min_r)) min_nxt = sample;
        if (!seen_r || (sample > max_r)) max_nxt = sample;
        sum_nxt   = sum_r + SUM_BITS'(sample);
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // restoring divider on magnitudes, one quotient bit per step
  assign rem_shift = {rem_r[COUNT_BITS-1:0], quo_r[SUM_BITS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, div_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    if (cmd.div_load) begin
      rem_nxt  = '0;
      quo_nxt  = sum_r[SUM_BITS-1] ? (~sum_r + 1'b1) : sum_r;
      div_nxt  = count_r;
      neg_nxt  = sum_r[SUM_BITS-1];
      step_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt  = rem_ge ? (rem_shift - {1'b0, div_r}) : rem_shift;
      quo_nxt  = {quo_r[SUM_BITS-2:0], rem_ge};
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
  end

  assign status.div_last = (step_r == STEP_BITS'(SUM_BITS - 1));

  // result capture; truncation toward zero comes from the magnitude divide
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign have_stats = seen_r && (count_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      min_out_r   <= have_stats ? min_r : '0;
      max_out_r   <= have_stats ? max_r : '0;
      mean_out_r  <= have_stats ? quo_signed[VALUE_BITS-1:0] : '0;
      count_out_r <= count_r;
      ovf_out_r   <= ovf_r;
    end
  end

  assign min_out     = min_out_r;
  assign max_out     = max_out_r;
  assign mean_out    = mean_out_r;
  assign match_count = count_out_r;
  assign overflow    = ovf_out_r;

endmodule

### hw/rtl/filtered_min_max_mean.sv
// Filtered running min/max/mean over a stream of sensor readings.
// Input transfer (in_ch): one reading per item; valid readings whose patient tag and
//   sensor type equal the configured targets are kept. Pressure readings use
//   the floored average of both values, others the first value.
// Output transfer (out_ch): one statistics result for each item marked last:
//   min, max, mean (sum / count toward zero), match count and overflow flag.
// Configuration: apb-style port, target_patient at 0x0, target_sensor at 0x4.
// Throughput: one item per cycle while no last item is pending.
// Sequence: after a last item is accepted, the mean takes a load step, then
//   VALUE_BITS + COUNT_BITS divider steps (40 at default widths) in a
//   bit-serial divider, then a capture into the output register. Input is
//   not accepted from the last item until that capture.
// Stall: a result held in the output register does not block accumulation;
//   only a second result waits for the first one to be taken.
// Reset: synchronous active-low; statistics clear, targets return to 0 and 'P'.
// Depends on fmm_pkg, fmm_if, fmm_cfg, fmm_ctrl and fmm_dp.
`timescale 1ns / 1ps

module filtered_min_max_mean
  import fmm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = FMM_VALUE_BITS,
  parameter int unsigned COUNT_BITS = FMM_COUNT_BITS
)(
  input  logic                     clk,
  input  logic                     rst_n,
  fmm_in_if.sink                   in_ch,
  fmm_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [CFG_REG_BITS-1:0] target_patient;
  logic [CFG_REG_BITS-1:0] target_sensor;
  fmm_cmd_t                cmd;
  fmm_status_t             status;

  // configuration registers
  fmm_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .target_patient (target_patient),
    .target_sensor  (target_sensor)
  );

  // sequencing
  fmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_reading),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // statistics and division
  fmm_dp #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .target_patient (target_patient),
    .target_sensor  (target_sensor),
    .reading_valid  (in_ch.reading_valid),
    .patient_tag    (in_ch.patient_tag),
    .sensor_type    (in_ch.sensor_type),
    .first_value    (in_ch.first_value),
    .second_value   (in_ch.second_value),
    .min_out        (out_ch.min_out),
    .max_out        (out_ch.max_out),
    .mean_out       (out_ch.mean_out),
    .match_count    (out_ch.match_count),
    .overflow       (out_ch.overflow)
  );

endmodule

### hw/rtl/fmm_checker.sv
// port-level checks for filtered_min_max_mean, attached by bind
// depends on fmm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fmm_checker
  import fmm_pkg::*;
#(
  parameter int unsigned VALUE_BITS = FMM_VALUE_BITS,
  parameter int unsigned COUNT_BITS = FMM_COUNT_BITS
)(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] min_out,
  input logic signed [VALUE_BITS-1:0] max_out,
  input logic signed [VALUE_BITS-1:0] mean_out,
  input logic [COUNT_BITS-1:0]        match_count,
  input logic                         overflow
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // an empty data set reports all-zero statistics
  `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, out_valid && (match_count == '0),
    (min_out == '0) && (max_out == '0) && (mean_out == '0))

  // extremes are ordered and the mean lies between them
  `ASSERT_IMPLIES(a_order, clk, rst_n, out_valid,
    (min_out <= max_out) && (mean_out >= min_out) && (mean_out <= max_out))

  // overflow only once the counter is saturated
  `ASSERT_IMPLIES(a_ovf_cap, clk, rst_n, out_valid && overflow,
    match_count == {COUNT_BITS{1'b1}})

  // input pauses while the mean of a finished data set is computed
  `ASSERT_NEXT(a_last_pause, clk, rst_n, in_valid && in_ready && in_last, !in_ready)

endmodule

bind filtered_min_max_mean fmm_checker #(
  .VALUE_BITS (VALUE_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_fmm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_reading),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .min_out     (out_ch.min_out),
  .max_out     (out_ch.max_out),
  .mean_out    (out_ch.mean_out),
  .match_count (out_ch.match_count),
  .overflow    (out_ch.overflow)
);

### sim/tb_top.sv
// testbench for filtered_min_max_mean: directed, stall and random reading streams
// with a self-checking statistics scoreboard; depends on fmm_pkg, fmm_if and the rtl
`timescale 1ns / 1ps

module tb_top;
  import fmm_pkg::*;

  localparam int VB = FMM_VALUE_BITS;
  localparam int CB = FMM_COUNT_BITS;
  localparam int COUNT_CAP = (1 << CB) - 1;
  localparam int GAP_MAX = 14;
  // divide latency plus some margin before touching the targets
  localparam int SETTLE_CYCLES = VB + CB + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int CYCLE_LIMIT = 500_000;
  localparam logic signed [VB-1:0] VALUE_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VALUE_MIN = {1'b1, {(VB-1){1'b0}}};

  typedef struct packed {
    logic                 reading_valid;
    logic [7:0]           patient_tag;
    logic [7:0]           sensor_type;
    logic signed [VB-1:0] first_value;
    logic signed [VB-1:0] second_value;
    logic                 last_reading;
  } reading_t;

  typedef struct packed {
    logic signed [VB-1:0] min_out;
    logic signed [VB-1:0] max_out;
    logic signed [VB-1:0] mean_out;
    logic [CB-1:0]        match_count;
    logic                 overflow;
  } stats_t;

  // running statistics predictor and the queue of statistics still due
  class stats_scoreboard;
    logic [7:0] patient_sel;
    logic [7:0] sensor_sel;
    bit         seen_any;
    longint     low_mark;
    longint     high_mark;
    longint     value_sum;
    int         kept_count;
    bit         capped;
    stats_t     pending_stats[$];
    int         failures;

    function new();
      patient_sel = TARGET_PATIENT_RST;
      sensor_sel  = TARGET_SENSOR_RST;
      failures    = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      seen_any   = 1'b0;
      low_mark   = 0;
      high_mark  = 0;
      value_sum  = 0;
      kept_count = 0;
      capped     = 1'b0;
    endfunction

    function void set_target(logic idx, logic [7:0] value);
      if (idx == REG_TARGET_PATIENT) begin
        patient_sel = value;
      end else begin
        sensor_sel = value;
      end
    endfunction

    // fold one accepted input transfer into the running statistics
    function void absorb_reading(reading_t r);
      longint sample;
      stats_t due;
      if (r.reading_valid && r.patient_tag == patient_sel && r.sensor_type == sensor_sel) begin
        // pressure uses the floored average of both values
        if (sensor_sel == PRESSURE_CODE) begin
          sample = (longint'(r.first_value) + longint'(r.second_value)) >>> 1;
        end else begin
          sample = longint'(r.first_value);
        end
        if (kept_count >= COUNT_CAP) begin
          capped = 1'b1;
        end else begin
          if (!seen_any) begin
            low_mark  = sample;
            high_mark = sample;
            seen_any  = 1'b1;
          end
          if (sample < low_mark) low_mark = sample;
          if (sample > high_mark) high_mark = sample;
          value_sum += sample;
          kept_count++;
        end
      end
      // end of data set: queue the statistics and start over
      if (r.last_reading) begin
        due = '0;
        if (seen_any && kept_count > 0) begin
          due.min_out  = VB'(low_mark);
          due.max_out  = VB'(high_mark);
          due.mean_out = VB'(value_sum / kept_count);
        end
        due.match_count = CB'(kept_count);
        due.overflow    = capped;
        pending_stats.push_back(due);
        clear_stats();
      end
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    // compare one output transfer with the oldest statistics due
    function void check_stats(stats_t got);
      stats_t want;
      if (pending_stats.size() == 0) begin
        $error("statistics result with nothing pending");
        failures++;
      end else begin
        want = pending_stats.pop_front();
        compare_field("min_out", want.min_out, got.min_out);
        compare_field("max_out", want.max_out, got.max_out);
        compare_field("mean_out", want.mean_out, got.mean_out);
        compare_field("match_count", want.match_count, got.match_count);
        compare_field("overflow", want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  fmm_in_if  in_ch ();
  fmm_out_if out_ch ();

  stats_scoreboard sb = new();

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int hold_cycles_req = 0;
  int cycle_count = 0;
  reading_t seen_in;
  stats_t seen_out;

  filtered_min_max_mean dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("filtered_min_max_mean regression: fail");
    $finish;
  end

  // observe both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_in.reading_valid = in_ch.reading_valid;
        seen_in.patient_tag   = in_ch.patient_tag;
        seen_in.sensor_type   = in_ch.sensor_type;
        seen_in.first_value   = in_ch.first_value;
        seen_in.second_value  = in_ch.second_value;
        seen_in.last_reading  = in_ch.last_reading;
        sb.absorb_reading(seen_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_out.min_out     = out_ch.min_out;
        seen_out.max_out     = out_ch.max_out;
        seen_out.mean_out    = out_ch.mean_out;
        seen_out.match_count = out_ch.match_count;
        seen_out.overflow    = out_ch.overflow;
        sb.check_stats(seen_out);
      end
    end
  end

  // result receiver with random stalls and requested long hold-offs
  initial begin
    int wait_cycles;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_cycles_req != 0) begin
        wait_cycles = hold_cycles_req;
        hold_cycles_req = 0;
      end else begin
        wait_cycles = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (wait_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
    end
  end

  function automatic reading_t make_reading(logic rv, logic [7:0] tag, logic [7:0] kind,
                                            logic signed [VB-1:0] a,
                                            logic signed [VB-1:0] b, logic last);
    reading_t r;
    r.reading_valid = rv;
    r.patient_tag   = tag;
    r.sensor_type   = kind;
    r.first_value   = a;
    r.second_value  = b;
    r.last_reading  = last;
    return r;
  endfunction

  // random value biased toward the extremes and small magnitudes
  function automatic logic signed [VB-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return VB'($urandom_range(0, 15)) - VB'(8);
      default: return VB'($urandom());
    endcase
  endfunction

  // one input transfer, after a random gap unless tx_burst is set; valid stays high afterwards
  task automatic send_reading(input reading_t r);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.reading_valid <= r.reading_valid;
    in_ch.patient_tag   <= r.patient_tag;
    in_ch.sensor_type   <= r.sensor_type;
    in_ch.first_value   <= r.first_value;
    in_ch.second_value  <= r.second_value;
    in_ch.last_reading  <= r.last_reading;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sender pauses until every statistics result has come, then the divider settles
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(APB_DATA_BITS-8)'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_target(idx, value);
  endtask

  task automatic set_targets(input logic [7:0] patient, input logic [7:0] kind);
    write_reg(REG_TARGET_PATIENT, patient);
    write_reg(REG_TARGET_SENSOR, kind);
  endtask

  // one random item: mostly kept readings, some mismatches and bare items
  function automatic reading_t random_item(logic last);
    case ($urandom_range(0, 9))
      7: return make_reading(1'b1, 8'($urandom()), sb.sensor_sel, pick_value(),
                             pick_value(), last);
      8: return make_reading(1'b1, sb.patient_sel, 8'($urandom()), pick_value(),
                             pick_value(), last);
      9: return make_reading(1'b0, 8'($urandom()), 8'($urandom()), pick_value(),
                             pick_value(), last);
      default: return make_reading(1'b1, sb.patient_sel, sb.sensor_sel, pick_value(),
                                   pick_value(), last);
    endcase
  endfunction

  // random data sets until enough items have gone in
  task automatic run_random_sets(input int target_items);
    int counted;
    int set_len;
    bit end_bare;
    reading_t r;
    counted = 0;
    while (counted < target_items) begin
      set_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      end_bare = ($urandom_range(0, 7) == 0);
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_len; i++) begin
        if (i == set_len - 1 && end_bare) begin
          r = make_reading(1'b0, 8'($urandom()), 8'($urandom()), pick_value(),
                           pick_value(), 1'b1);
        end else begin
          r = random_item(i == set_len - 1);
        end
        counted++;
        send_reading(r);
      end
    end
  endtask

  // main sequence
  initial begin
    logic [7:0] patient;
    logic [7:0] kind;
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.reading_valid <= 1'b0;
    in_ch.patient_tag   <= '0;
    in_ch.sensor_type   <= '0;
    in_ch.first_value   <= '0;
    in_ch.second_value  <= '0;
    in_ch.last_reading  <= 1'b0;
    out_ch.ready        <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset targets: patient 0, pressure averaging
    send_reading(make_reading(1'b0, 8'h00, PRESSURE_CODE, '0, '0, 1'b1));
    send_reading(make_reading(1'b1, 8'h00, PRESSURE_CODE, VALUE_MAX, VALUE_MAX, 1'b0));
    send_reading(make_reading(1'b1, 8'h00, PRESSURE_CODE, VALUE_MIN, VALUE_MIN, 1'b0));
    send_reading(make_reading(1'b1, 8'h00, PRESSURE_CODE, -24'sd1, 24'sd0, 1'b0));
    send_reading(make_reading(1'b1, 8'h00, PRESSURE_CODE, VALUE_MAX, VALUE_MIN, 1'b0));
    send_reading(make_reading(1'b1, 8'h01, PRESSURE_CODE, 24'sd77, 24'sd9, 1'b0));
    send_reading(make_reading(1'b1, 8'h00, 8'h51, 24'sd77, 24'sd9, 1'b0));
    send_reading(make_reading(1'b0, 8'h00, PRESSURE_CODE, 24'sd77, 24'sd9, 1'b0));
    // reading on the last item counts
    send_reading(make_reading(1'b1, 8'h00, PRESSURE_CODE, 24'sd1, 24'sd0, 1'b1));
    wait_results_drained();

    // directed, first value only
    set_targets(8'hFF, 8'h00);
    send_reading(make_reading(1'b1, 8'hFF, 8'h00, VALUE_MAX, VALUE_MIN, 1'b0));
    send_reading(make_reading(1'b1, 8'hFF, 8'h00, VALUE_MIN, VALUE_MAX, 1'b1));
    // negative mean truncates toward zero
    send_reading(make_reading(1'b1, 8'hFF, 8'h00, -24'sd3, VALUE_MAX, 1'b0));
    send_reading(make_reading(1'b1, 8'hFF, 8'h00, 24'sd0, VALUE_MIN, 1'b1));
    // nothing kept, last item mismatched
    send_reading(make_reading(1'b1, 8'hFE, 8'h00, 24'sd5, 24'sd0, 1'b1));
    send_reading(make_reading(1'b1, 8'hFF, PRESSURE_CODE, 24'sd5, 24'sd0, 1'b1));
    wait_results_drained();

    // receiver holds off while the sender keeps going
    hold_cycles_req = HOLD_CYCLES;
    tx_burst = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_reading(random_item(i % 4 == 3));
    end
    wait_results_drained();

    // random phases, each with its own targets
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          patient = 8'h00;
          kind    = PRESSURE_CODE;
        end
        1: begin
          patient = 8'hFF;
          kind    = 8'hFF;
        end
        2: begin
          patient = 8'($urandom());
          kind    = 8'h00;
        end
        default: begin
          patient = 8'($urandom());
          kind    = ($urandom_range(0, 1) == 0) ? PRESSURE_CODE : 8'($urandom());
        end
      endcase
      set_targets(patient, kind);
      run_random_sets(ITEMS_PER_PHASE);
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending_stats.size() == 0) begin
      $display("filtered_min_max_mean regression: pass");
    end else begin
      $display("filtered_min_max_mean regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/fmm_pkg.sv
hw/rtl/fmm_if.sv
hw/rtl/fmm_cfg.sv
hw/rtl/fmm_ctrl.sv
hw/rtl/fmm_dp.sv
hw/rtl/filtered_min_max_mean.sv
hw/rtl/fmm_checker.sv
sim/tb_top.sv
